// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/rdpd_pkg.sv -----
// ---------------------------------------------------------------------------
// rdpd_pkg
// Types, widths and constants shared by the rotary dial pulse decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdpd_pkg;

	localparam int HOOK_W        = 8;
	localparam int LINE_W        = 3;
	localparam int DIGIT_W       = 4;
	localparam int CFG_W         = 16;
	localparam int LINES_CFG_W   = 4;
	localparam int CFG_IDX_W     = 2;

	localparam int MAX_LINES_DEF = 8;
	localparam int TIME_BITS_DEF = 32;

	localparam logic [CFG_W-1:0]       DEBOUNCE_RST = 16'd10;
	localparam logic [CFG_W-1:0]       GAP_RST      = 16'd100;
	localparam logic [LINES_CFG_W-1:0] LINES_RST    = 4'd8;

	// Pulse count wraps from this value back to zero.
	localparam logic [DIGIT_W-1:0] DIGIT_LAST = 4'd9;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_GAP      = 2'd1,
		CFG_LINES    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		EV_START = 1'b0,
		EV_DIGIT = 1'b1
	} event_kind_t;

	typedef struct packed {
		logic                fire;
		event_kind_t         kind;
		logic [DIGIT_W-1:0]  digit;
	} lane_event_t;

endpackage

// ----- rtl/core/rdpd_lane.sv -----
// ---------------------------------------------------------------------------
// rdpd_lane
// Per-line debounce, pulse counting and digit detection for one tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rdpd_lane #(
	parameter int TIME_BITS = rdpd_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          rearm,
	input  logic                          en,
	input  logic                          level,
	input  logic [TIME_BITS-1:0]          now,
	input  logic [rdpd_pkg::CFG_W-1:0]    debounce_min,
	input  logic [rdpd_pkg::CFG_W-1:0]    gap_max,
	output rdpd_pkg::lane_event_t         ev
);
	import rdpd_pkg::*;

	logic                 raw_q, stable_q, evalid_q, inpulse_q, dial_q;
	logic [TIME_BITS-1:0] dstamp_q, estamp_q;
	logic [DIGIT_W-1:0]   count_q;

	logic                 raw_d, stable_d, evalid_d, inpulse_d, dial_d;
	logic [TIME_BITS-1:0] dstamp_d, estamp_d;
	logic [DIGIT_W-1:0]   count_d;

	logic [TIME_BITS-1:0] held, gap, dmin_ext, gmax_ext;
	logic                 hold;

	assign dmin_ext = TIME_BITS'(debounce_min);
	assign gmax_ext = TIME_BITS'(gap_max);

	always_comb begin
		// re-arm first, then decode against the re-armed state
		raw_d     = raw_q;
		stable_d  = stable_q;
		estamp_d  = estamp_q;
		inpulse_d = rearm ? 1'b0 : inpulse_q;
		dial_d    = rearm ? 1'b0 : dial_q;
		count_d   = rearm ? '0 : count_q;
		evalid_d  = rearm ? 1'b0 : evalid_q;
		dstamp_d  = rearm ? now : dstamp_q;
		ev        = '{fire: 1'b0, kind: EV_START, digit: '0};

		held = now - dstamp_d;
		gap  = evalid_d ? (now - estamp_q) : '0;
		hold = (level && stable_q && (gap <= gmax_ext)) || (!level && !stable_q);

		if (en) begin
			if (level != raw_q) begin
				raw_d    = level;
				dstamp_d = now;
			end else if (held >= dmin_ext && !hold) begin
				stable_d = level;
				// a high right after re-arm settles with no edge to act on
				if (!level && !inpulse_d) begin
					inpulse_d = 1'b1;
					estamp_d  = now;
					evalid_d  = 1'b1;
				end else if (level && inpulse_d) begin
					inpulse_d = 1'b0;
					count_d   = (count_d == DIGIT_LAST) ? '0 : count_d + 1'b1;
					estamp_d  = now;
					evalid_d  = 1'b1;
					if (!dial_d) begin
						dial_d = 1'b1;
						ev     = '{fire: 1'b1, kind: EV_START, digit: '0};
					end
				end else if (level && !inpulse_d && gap > gmax_ext) begin
					ev       = '{fire: 1'b1, kind: EV_DIGIT, digit: count_d};
					count_d  = '0;
					evalid_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q     <= 1'b0;
			stable_q  <= 1'b0;
			evalid_q  <= 1'b0;
			inpulse_q <= 1'b0;
			dial_q    <= 1'b0;
			count_q   <= '0;
			dstamp_q  <= '0;
		end else if (tick) begin
			raw_q     <= raw_d;
			stable_q  <= stable_d;
			evalid_q  <= evalid_d;
			inpulse_q <= inpulse_d;
			dial_q    <= dial_d;
			count_q   <= count_d;
			dstamp_q  <= dstamp_d;
		end
	end

	// edge stamp is only read while evalid_q is set
	always_ff @(posedge clk) begin
		if (tick) begin
			estamp_q <= estamp_d;
		end
	end

	`ASSERT_CLK(a_count_range, count_q <= DIGIT_LAST, "pulse count left 0..9")
	`ASSERT_NEVER(a_fire_idle_line, ev.fire && !en, "event raised on a line not in use")
	`ASSERT_NEVER(a_start_no_digit, ev.fire && ev.kind == EV_START && ev.digit != '0, "start with digit")

endmodule

// ----- rtl/core/rdpd_merge.sv -----
// ---------------------------------------------------------------------------
// rdpd_merge
// Collect lane events of one tick and send them out lowest line first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rdpd_merge #(
	parameter int LANES = rdpd_pkg::MAX_LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  rdpd_pkg::lane_event_t         ev [LANES],
	output logic                          take_ok,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rdpd_pkg::LINE_W-1:0]   line_number,
	output logic                          event_kind,
	output logic [rdpd_pkg::DIGIT_W-1:0]  digit_value,
	output logic                          last_of_run
);
	import rdpd_pkg::*;

	localparam logic [LANES-1:0] ONE = LANES'(1);

	logic [LANES-1:0]   pend_q, rest;
	event_kind_t        kind_q  [LANES];
	logic [DIGIT_W-1:0] digit_q [LANES];

	logic               pop;
	logic [LINE_W-1:0]  sel_line;
	event_kind_t        sel_kind;
	logic [DIGIT_W-1:0] sel_digit;

	logic               out_valid_q, last_q, kind_out_q;
	logic [LINE_W-1:0]  line_q;
	logic [DIGIT_W-1:0] digit_out_q;

	always_comb begin
		sel_line  = '0;
		sel_kind  = EV_START;
		sel_digit = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel_line  = LINE_W'(i);
				sel_kind  = kind_q[i];
				sel_digit = digit_q[i];
			end
		end
	end

	// drop the lowest pending line
	assign rest    = pend_q & (pend_q - ONE);
	assign pop     = (pend_q != '0) && (!out_valid_q || out_ready);
	assign take_ok = (pend_q == '0) || (pop && rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			for (int i = 0; i < LANES; i++) begin
				pend_q[i] <= ev[i].fire;
			end
		end else if (pop) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < LANES; i++) begin
				kind_q[i]  <= ev[i].kind;
				digit_q[i] <= ev[i].digit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			line_q      <= sel_line;
			kind_out_q  <= sel_kind;
			digit_out_q <= sel_digit;
			last_q      <= (rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = line_q;
	assign event_kind  = kind_out_q;
	assign digit_value = digit_out_q;
	assign last_of_run = last_q;

	`ASSERT_CLK(a_run_tail_pending, (out_valid_q && !last_q) |-> (pend_q != '0), "run cut short")
	`ASSERT_CLK(a_no_load_over_run, ($countones(pend_q) > 1) |-> !take_ok, "tick taken over run")
	`ASSERT_CLK(a_out_hold, (out_valid_q && !out_ready) |=> (out_valid_q && $stable(line_q)), "word lost")

endmodule

// ----- rtl/core/rotary_dial_pulse_decoder_top.sv -----
// ---------------------------------------------------------------------------
// rotary_dial_pulse_decoder_top
// Rotary dial pulse decoder: one input word per millisecond tick, one output
// word per dialing-started or digit-received event.
// ---------------------------------------------------------------------------
// Path: a tick's events go into the merge stage's pending set, then the output
// register. Flow: a tick word is taken only when no line is pending or the last
// one is being passed on; the merge stage drains one line per cycle into the
// single output register whenever that register is empty or being read.
// Reset: asynchronous, clears tick clock, line state bar the edge stamps, and
// out_valid; configuration returns to debounce 10, digit gap 100, eight lines.
`timescale 1ns / 1ps

module rotary_dial_pulse_decoder_top #(
	parameter int MAX_LINES = rdpd_pkg::MAX_LINES_DEF,
	parameter int TIME_BITS = rdpd_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rdpd_pkg::HOOK_W-1:0]       hook_levels,
	input  logic                              rearm,
	// event words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rdpd_pkg::LINE_W-1:0]       line_number,
	output logic                              event_kind,
	output logic [rdpd_pkg::DIGIT_W-1:0]      digit_value,
	output logic                              last_of_run,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [rdpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rdpd_pkg::CFG_W-1:0]        cfg_wdata
);
	import rdpd_pkg::*;

	// lanes past the width of the hook word can never be decoded
	localparam int LANES = (MAX_LINES > HOOK_W) ? HOOK_W : MAX_LINES;

	logic [CFG_W-1:0]       dmin_q, gmax_q;
	logic [LINES_CFG_W-1:0] lines_q;
	logic [TIME_BITS-1:0]   tick_q, now;
	logic                   tick;
	lane_event_t            lane_ev [LANES];

	assign tick = in_valid && in_ready;
	// the tick clock advances before anything else looks at it
	assign now  = tick_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q  <= DEBOUNCE_RST;
			gmax_q  <= GAP_RST;
			lines_q <= LINES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: dmin_q  <= cfg_wdata;
				CFG_GAP:      gmax_q  <= cfg_wdata;
				CFG_LINES:    lines_q <= cfg_wdata[LINES_CFG_W-1:0];
				default: begin
					// index past the register list: ignore the write
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (tick) begin
			tick_q <= now;
		end
	end

	// one decoder lane per phone line, all stepping on the same tick
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		rdpd_lane #(
			.TIME_BITS(TIME_BITS)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.tick         (tick),
			.rearm        (rearm),
			.en           (lines_q > LINES_CFG_W'(g)),
			.level        (hook_levels[g]),
			.now          (now),
			.debounce_min (dmin_q),
			.gap_max      (gmax_q),
			.ev           (lane_ev[g])
		);
	end

	// serialize the lane events of a tick, lowest line first
	rdpd_merge #(
		.LANES(LANES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (tick),
		.ev          (lane_ev),
		.take_ok     (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.line_number (line_number),
		.event_kind  (event_kind),
		.digit_value (digit_value),
		.last_of_run (last_of_run)
	);

endmodule
